// ===== hw/rtl/rmc_pkg.sv =====
// Package for the range membership counter.
// Holds table sizing, character codes, result kinds and the structs that
// pass between the front end and the range cells. No dependencies.
package rmc_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int VAL_W       = 64;
   localparam int HIT_W       = 32;
   localparam int HELD_W      = 9;
   localparam int KIND_W      = 2;

   localparam logic [7:0] CH_ZERO = 8'd48;
   localparam logic [7:0] CH_NINE = 8'd57;
   localparam logic [7:0] CH_DASH = 8'd45;

   localparam logic [HIT_W-1:0] HIT_MAX = '1;

   localparam logic [KIND_W-1:0] EV_STORED  = 2'd0;
   localparam logic [KIND_W-1:0] EV_DROPPED = 2'd1;
   localparam logic [KIND_W-1:0] EV_QUERY   = 2'd2;

   // Write of one range pair into the cell whose index matches.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] low;
      logic [VAL_W-1:0] high;
   } rmc_wr_type;

   // Query token that walks the cell chain, collecting a hit on the way.
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [VAL_W-1:0] value;
   } rmc_tok_type;

endpackage

// ===== hw/rtl/rmc_cell.sv =====
// One cell of the range table: holds a single low/high pair and a valid bit.
// Checks the passing query token against its range and hands it on.
// Depends on rmc_pkg.
module rmc_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [rmc_pkg::IDX_W-1:0] cell_idx,
   input  rmc_pkg::rmc_wr_type       wr,
   input  rmc_pkg::rmc_tok_type      tok_in,
   output rmc_pkg::rmc_tok_type      tok_out
);

   logic                      used_ff;
   logic [rmc_pkg::VAL_W-1:0] low_ff;
   logic [rmc_pkg::VAL_W-1:0] high_ff;
   rmc_pkg::rmc_tok_type      tok_ff;
   rmc_pkg::rmc_tok_type      tok_in_next;
   logic                      wr_here;
   logic                      match;

   assign wr_here = wr.en && (wr.idx == cell_idx);
   assign match   = used_ff && (tok_in.value >= low_ff) && (tok_in.value <= high_ff);

   always_comb begin
      tok_in_next       = tok_in;
      tok_in_next.hit   = tok_in.hit | match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         if (wr_here) begin
            used_ff <= 1'b1;
         end
         tok_ff.valid <= tok_in_next.valid;
      end
      tok_ff.hit   <= tok_in_next.hit;
      tok_ff.value <= tok_in_next.value;
      if (wr_here) begin
         low_ff  <= wr.low;
         high_ff <= wr.high;
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== hw/rtl/rmc_front.sv =====
// Front end of the range membership counter: character decode, number
// accumulation, range table fill, query launch and result registers.
// Depends on rmc_pkg.
module rmc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [7:0]                  req_char_byte,
   output logic                        rsp_strobe,
   output logic [rmc_pkg::KIND_W-1:0]  rsp_event_kind,
   output logic                        rsp_query_hit,
   output logic [rmc_pkg::HIT_W-1:0]   rsp_hit_total,
   output logic [rmc_pkg::HELD_W-1:0]  rsp_ranges_held,
   output rmc_pkg::rmc_wr_type         wr,
   output rmc_pkg::rmc_tok_type        tok_launch,
   input  rmc_pkg::rmc_tok_type        tok_done
);

   localparam logic ST_IDLE   = 1'b0;
   localparam logic ST_SEARCH = 1'b1;

   logic                         state_ff, state_in;
   logic [rmc_pkg::VAL_W-1:0]    accum_ff, accum_in;
   logic                         digit_ff, digit_in;
   logic                         dash_ff, dash_in;
   logic [rmc_pkg::VAL_W-1:0]    plow_ff, plow_in;
   logic [rmc_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [rmc_pkg::HIT_W-1:0]    hits_ff, hits_in;
   logic                         launch_ff, launch_in;
   logic [rmc_pkg::VAL_W-1:0]    qval_ff, qval_in;
   logic                         strobe_ff, strobe_in;
   logic [rmc_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic                         qhit_ff, qhit_in;

   logic                         accept;
   logic                         is_digit;
   logic                         is_dash;
   logic                         room;
   logic [rmc_pkg::VAL_W-1:0]    digit_val;

   assign accept    = start && (state_ff == ST_IDLE);
   assign is_digit  = (req_char_byte >= rmc_pkg::CH_ZERO) && (req_char_byte <= rmc_pkg::CH_NINE);
   assign is_dash   = (req_char_byte == rmc_pkg::CH_DASH);
   assign room      = (count_ff < rmc_pkg::CNT_W'(rmc_pkg::TABLE_DEPTH));
   assign digit_val = rmc_pkg::VAL_W'(req_char_byte - rmc_pkg::CH_ZERO);

   always_comb begin
      state_in  = state_ff;
      accum_in  = accum_ff;
      digit_in  = digit_ff;
      dash_in   = dash_ff;
      plow_in   = plow_ff;
      count_in  = count_ff;
      hits_in   = hits_ff;
      launch_in = 1'b0;
      qval_in   = accum_ff;
      strobe_in = 1'b0;
      kind_in   = kind_ff;
      qhit_in   = 1'b0;
      wr.en     = 1'b0;
      wr.idx    = count_ff[rmc_pkg::IDX_W-1:0];
      wr.low    = plow_ff;
      wr.high   = accum_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_digit) begin
                  // Times ten as two shifts and an add, wrapping modulo 2^64.
                  accum_in = (accum_ff << 3) + (accum_ff << 1) + digit_val;
                  digit_in = 1'b1;
               end else if (is_dash) begin
                  plow_in  = accum_ff;
                  dash_in  = 1'b1;
                  accum_in = '0;
                  digit_in = 1'b0;
               end else begin
                  accum_in = '0;
                  digit_in = 1'b0;
                  if (dash_ff) begin
                     dash_in   = 1'b0;
                     strobe_in = 1'b1;
                     if (room) begin
                        wr.en    = 1'b1;
                        count_in = count_ff + rmc_pkg::CNT_W'(1);
                        kind_in  = rmc_pkg::EV_STORED;
                     end else begin
                        kind_in  = rmc_pkg::EV_DROPPED;
                     end
                  end else if (digit_ff) begin
                     launch_in = 1'b1;
                     state_in  = ST_SEARCH;
                  end
               end
            end
         end
         ST_SEARCH: begin
            if (tok_done.valid) begin
               state_in  = ST_IDLE;
               strobe_in = 1'b1;
               kind_in   = rmc_pkg::EV_QUERY;
               qhit_in   = tok_done.hit;
               if (tok_done.hit && (hits_ff != rmc_pkg::HIT_MAX)) begin
                  hits_in = hits_ff + rmc_pkg::HIT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         accum_ff  <= '0;
         digit_ff  <= 1'b0;
         dash_ff   <= 1'b0;
         plow_ff   <= '0;
         count_ff  <= '0;
         hits_ff   <= '0;
         launch_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         accum_ff  <= accum_in;
         digit_ff  <= digit_in;
         dash_ff   <= dash_in;
         plow_ff   <= plow_in;
         count_ff  <= count_in;
         hits_ff   <= hits_in;
         launch_ff <= launch_in;
         strobe_ff <= strobe_in;
      end
      qval_ff <= qval_in;
      kind_ff <= kind_in;
      qhit_ff <= qhit_in;
   end

   assign busy             = (state_ff == ST_SEARCH);
   assign tok_launch.valid = launch_ff;
   assign tok_launch.hit   = 1'b0;
   assign tok_launch.value = qval_ff;

   assign rsp_strobe     = strobe_ff;
   assign rsp_event_kind = kind_ff;
   assign rsp_query_hit  = qhit_ff;
   // The total and count registers already hold the values after this item.
   assign rsp_hit_total  = hits_ff;

   generate
      if (rmc_pkg::CNT_W >= rmc_pkg::HELD_W) begin : g_held_trunc
         assign rsp_ranges_held = count_ff[rmc_pkg::HELD_W-1:0];
      end else begin : g_held_ext
         assign rsp_ranges_held = {{(rmc_pkg::HELD_W - rmc_pkg::CNT_W){1'b0}}, count_ff};
      end
   endgenerate

endmodule

// ===== hw/rtl/range_membership_counter_top.sv =====
// Range membership counter, top level. Digit and dash items give no result;
// a range terminator gives its result in the cycle after it is taken.
// A query walks the chain of TABLE_DEPTH range cells one cell per cycle, so busy
// stays high until the query result appears.
// Synchronous active-high reset empties the table and clears all counters.
// The receiver cannot stall: each result is shown for exactly one cycle.
module range_membership_counter_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [7:0]                  req_char_byte,
   output logic                        rsp_strobe,
   output logic [rmc_pkg::KIND_W-1:0]  rsp_event_kind,
   output logic                        rsp_query_hit,
   output logic [rmc_pkg::HIT_W-1:0]   rsp_hit_total,
   output logic [rmc_pkg::HELD_W-1:0]  rsp_ranges_held
);

   rmc_pkg::rmc_wr_type  wr;
   rmc_pkg::rmc_tok_type tok_chain [0:rmc_pkg::TABLE_DEPTH];

   rmc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_char_byte   (req_char_byte),
      .rsp_strobe      (rsp_strobe),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_query_hit   (rsp_query_hit),
      .rsp_hit_total   (rsp_hit_total),
      .rsp_ranges_held (rsp_ranges_held),
      .wr              (wr),
      .tok_launch      (tok_chain[0]),
      .tok_done        (tok_chain[rmc_pkg::TABLE_DEPTH])
   );

   genvar gi;
   generate
      for (gi = 0; gi < rmc_pkg::TABLE_DEPTH; gi++) begin : g_cell
         rmc_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .cell_idx (rmc_pkg::IDX_W'(gi)),
            .wr       (wr),
            .tok_in   (tok_chain[gi]),
            .tok_out  (tok_chain[gi+1])
         );
      end
   endgenerate

`ifndef SYNTH
   // No result may leave while a query is still walking the chain.
   a_no_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("result strobe while busy");

   // A query answer always ends a search.
   a_query_after_search: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_event_kind == rmc_pkg::EV_QUERY)) |-> $past(busy))
      else $error("query answer without a search");

   // Only query answers carry a hit.
   a_hit_only_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_event_kind != rmc_pkg::EV_QUERY)) |-> !rsp_query_hit)
      else $error("hit flagged on a range event");

   // A dropped range means the table is full.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_event_kind == rmc_pkg::EV_DROPPED)) |->
      (rsp_ranges_held == rmc_pkg::HELD_W'(rmc_pkg::TABLE_DEPTH)))
      else $error("range dropped with room left");
`endif

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench for range_membership_counter_top: drives character bytes, predicts each
// range store, drop and query in a small tracker class and checks every result.
// Depends on rmc_pkg and the range_membership_counter_top RTL.
module tb;

   typedef struct {
      logic [rmc_pkg::KIND_W-1:0] kind;
      logic                       hit;
      logic [rmc_pkg::HIT_W-1:0]  total;
      logic [rmc_pkg::HELD_W-1:0] held;
   } tally_type;

   // Tracks the range table and the running hit count, and holds the results
   // still owed by the block, oldest first.
   class membership_tracker;
      logic [rmc_pkg::VAL_W-1:0] accum;
      logic [rmc_pkg::VAL_W-1:0] pending_low;
      bit                        digit_seen;
      bit                        dash_pending;
      logic [rmc_pkg::VAL_W-1:0] low_bound [rmc_pkg::TABLE_DEPTH];
      logic [rmc_pkg::VAL_W-1:0] high_bound [rmc_pkg::TABLE_DEPTH];
      int unsigned               range_count;
      logic [rmc_pkg::HIT_W-1:0] hit_total;
      tally_type                 due [$];
      int                        mismatches;
      int                        stored_seen;
      int                        dropped_seen;
      int                        queries_seen;
      int                        hits_seen;

      function new();
         accum        = '0;
         pending_low  = '0;
         digit_seen   = 1'b0;
         dash_pending = 1'b0;
         range_count  = 0;
         hit_total    = '0;
         mismatches   = 0;
         stored_seen  = 0;
         dropped_seen = 0;
         queries_seen = 0;
         hits_seen    = 0;
      endfunction

      function bit covers(logic [rmc_pkg::VAL_W-1:0] v);
         for (int i = 0; i < range_count && i < rmc_pkg::TABLE_DEPTH; i++) begin
            if (v >= low_bound[i] && v <= high_bound[i])
               return 1'b1;
         end
         return 1'b0;
      endfunction

      function void take_char(logic [7:0] ch);
         tally_type rec;
         bit        owed;
         owed    = 1'b0;
         rec.hit = 1'b0;
         if (ch >= rmc_pkg::CH_ZERO && ch <= rmc_pkg::CH_NINE) begin
            accum      = accum * 64'd10 + {56'd0, ch - rmc_pkg::CH_ZERO};
            digit_seen = 1'b1;
         end else if (ch == rmc_pkg::CH_DASH) begin
            pending_low  = accum;
            dash_pending = 1'b1;
            accum        = '0;
            digit_seen   = 1'b0;
         end else begin
            if (dash_pending) begin
               if (range_count < rmc_pkg::TABLE_DEPTH) begin
                  low_bound[range_count]  = pending_low;
                  high_bound[range_count] = accum;
                  range_count++;
                  rec.kind = rmc_pkg::EV_STORED;
                  stored_seen++;
               end else begin
                  rec.kind = rmc_pkg::EV_DROPPED;
                  dropped_seen++;
               end
               dash_pending = 1'b0;
               owed         = 1'b1;
            end else if (digit_seen) begin
               rec.hit = covers(accum);
               if (rec.hit) begin
                  hits_seen++;
                  if (hit_total != rmc_pkg::HIT_MAX)
                     hit_total++;
               end
               rec.kind = rmc_pkg::EV_QUERY;
               queries_seen++;
               owed     = 1'b1;
            end
            accum      = '0;
            digit_seen = 1'b0;
         end
         if (owed) begin
            rec.total = hit_total;
            rec.held  = range_count[rmc_pkg::HELD_W-1:0];
            due.push_back(rec);
         end
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH at %0t: %s", $time, msg);
      endfunction

      function void check_result(logic [rmc_pkg::KIND_W-1:0] kind, logic hit,
                                 logic [rmc_pkg::HIT_W-1:0] total,
                                 logic [rmc_pkg::HELD_W-1:0] held);
         tally_type want;
         if (due.size() == 0) begin
            flag($sformatf("unexpected result kind %0d hit %0d total %0d held %0d",
                           kind, hit, total, held));
            return;
         end
         want = due.pop_front();
         if (kind !== want.kind || hit !== want.hit || total !== want.total ||
             held !== want.held)
            flag($sformatf({"expected kind %0d hit %0d total %0d held %0d, ",
                            "got kind %0d hit %0d total %0d held %0d"},
                           want.kind, want.hit, want.total, want.held,
                           kind, hit, total, held));
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [7:0]                   req_char_byte;
   logic                         rsp_strobe;
   logic [rmc_pkg::KIND_W-1:0]   rsp_event_kind;
   logic                         rsp_query_hit;
   logic [rmc_pkg::HIT_W-1:0]    rsp_hit_total;
   logic [rmc_pkg::HELD_W-1:0]   rsp_ranges_held;

   membership_tracker   board;
   int                  chars_taken;
   int                  gap_pct;

   range_membership_counter_top uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_char_byte   (req_char_byte),
      .rsp_strobe      (rsp_strobe),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_query_hit   (rsp_query_hit),
      .rsp_hit_total   (rsp_hit_total),
      .rsp_ranges_held (rsp_ranges_held)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board.check_result(rsp_event_kind, rsp_query_hit, rsp_hit_total, rsp_ranges_held);
   end

   initial begin
      #(30_000_000);
      $display("Timed out with %0d results still owed.", board.due.size());
      $display("** range_membership_counter_top: FAILED **");
      $finish;
   end

   task automatic idle_after();
      int n;
      if ($urandom_range(0, 99) >= gap_pct)
         return;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      @(negedge clock);
      start = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Holds the item on the inputs until the block takes it.
   task automatic send_char(input logic [7:0] ch);
      @(negedge clock);
      start         = 1'b1;
      req_char_byte = ch;
      do
         @(posedge clock);
      while (busy);
      board.take_char(ch);
      chars_taken++;
      idle_after();
   endtask

   task automatic send_decimal(input logic [rmc_pkg::VAL_W-1:0] v);
      string s;
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i]);
   endtask

   task automatic send_digit_run(input int n);
      repeat (n) send_char(rmc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
   endtask

   // Any operand: mostly small, sometimes long enough to wrap the accumulator.
   task automatic send_operand();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         send_decimal($urandom_range(0, 99));
      else if (pick < 75)
         send_decimal($urandom_range(0, 9999));
      else if (pick < 85)
         send_decimal({$urandom, $urandom});
      else if (pick < 93)
         send_digit_run($urandom_range(18, 25));
      else if (pick < 97)
         send_decimal('1);
      else begin
         send_digit_run(0);
         send_char(rmc_pkg::CH_ZERO);
         send_decimal($urandom_range(0, 99));
      end
   endtask

   task automatic send_terminator();
      int          pick;
      logic [7:0]  ch;
      pick = $urandom_range(0, 99);
      if (pick < 40)
         send_char(8'h0A);
      else if (pick < 55) begin
         send_char(8'h0D);
         send_char(8'h0A);
      end else if (pick < 70)
         send_char(",");
      else if (pick < 80)
         send_char(" ");
      else begin
         do
            ch = 8'($urandom_range(0, 255));
         while ((ch >= rmc_pkg::CH_ZERO && ch <= rmc_pkg::CH_NINE) ||
                ch == rmc_pkg::CH_DASH);
         send_char(ch);
      end
   endtask

   // A value near a stored range when there is one, so that queries hit often.
   function automatic logic [rmc_pkg::VAL_W-1:0] probe_value();
      int                        idx;
      int                        filled;
      logic [rmc_pkg::VAL_W-1:0] lo;
      logic [rmc_pkg::VAL_W-1:0] hi;
      filled = (board.range_count < rmc_pkg::TABLE_DEPTH) ? board.range_count :
               rmc_pkg::TABLE_DEPTH;
      if (filled == 0 || $urandom_range(0, 99) < 50)
         return $urandom_range(0, 140);
      idx = $urandom_range(0, filled - 1);
      lo  = board.low_bound[idx];
      hi  = board.high_bound[idx];
      case ($urandom_range(0, 4))
         0: return lo;
         1: return hi;
         2: return lo - 1;
         3: return hi + 1;
         default: return lo + (hi - lo) / 2;
      endcase
   endfunction

   task automatic send_range();
      int                        pick;
      logic [rmc_pkg::VAL_W-1:0] lo_v;
      if ($urandom_range(0, 99) < 5) begin
         send_operand();
         send_char(rmc_pkg::CH_DASH);
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
         lo_v = $urandom_range(0, 99);
         send_decimal(lo_v);
         send_char(rmc_pkg::CH_DASH);
         pick = $urandom_range(0, 99);
         if (pick < 85)
            send_decimal(lo_v + $urandom_range(0, 30));
         else if (pick < 92)
            send_decimal($urandom_range(0, 99));
      end else if (pick < 88) begin
         send_operand();
         send_char(rmc_pkg::CH_DASH);
         send_operand();
      end else if (pick < 94) begin
         send_char(rmc_pkg::CH_DASH);
         send_operand();
      end else begin
         send_operand();
         send_char(rmc_pkg::CH_DASH);
      end
      send_terminator();
   endtask

   task automatic send_query();
      if ($urandom_range(0, 99) < 70)
         send_decimal(probe_value());
      else
         send_operand();
      send_terminator();
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0)
         send_terminator();
   endtask

   initial begin
      logic [7:0] opening [24];
      int pick;
      bit filling;
      bit failed;

      opening = '{
         8'h0A, "5", 8'h0A, "-", 8'h0A, "0", 8'h0D, 8'h0A,
         "7", "-", "3", "-", "9", ",", "4", "-", 8'h0A,
         "9", 8'hFF, "8", 8'h00, "3", "/", ":"};
      reset         = 1'b1;
      start         = 1'b0;
      req_char_byte = 8'h00;
      board         = new();
      chars_taken   = 0;
      gap_pct       = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Blank terminators, an empty-table miss, empty bounds, a replaced low bound,
      // boundary bytes around the digits, and the bytes with all bits clear and set.
      foreach (opening[i])
         send_char(opening[i]);

      while (chars_taken < 1950 || board.dropped_seen < 12) begin
         case ($urandom_range(0, 3))
            0, 1: gap_pct = 0;
            2: gap_pct = 25;
            default: gap_pct = 50;
         endcase
         filling = board.range_count < rmc_pkg::TABLE_DEPTH;
         pick    = $urandom_range(0, 99);
         if (pick < (filling ? 88 : 60))
            send_range();
         else if (pick < 93)
            send_query();
         else
            send_noise();
      end

      @(negedge clock);
      start = 1'b0;
      while (board.due.size() != 0)
         @(posedge clock);
      repeat (rmc_pkg::TABLE_DEPTH + 4) @(posedge clock);

      failed = board.mismatches != 0 || board.due.size() != 0;
      $display("Sent %0d characters: %0d ranges stored, %0d dropped on a full table,",
               chars_taken, board.stored_seen, board.dropped_seen);
      $display("%0d queries with %0d hits; %0d mismatches.",
               board.queries_seen, board.hits_seen, board.mismatches);
      if (!failed)
         $display("** range_membership_counter_top: PASSED **");
      else
         $display("** range_membership_counter_top: FAILED **");
      $finish;
   end
endmodule
